>>> design/rsq_pkg.sv
package rsq_pkg;

    // Quarter-wave sine series: eight Taylor terms after the first
    localparam int SIN_TERMS = 8;

    // Angle reduction, squaring, three stages per term, accumulate, round
    localparam int SIN_LATENCY = 2 + 3 * SIN_TERMS + 2;

    // pi/2 in Q30 and one quarter turn in binary angle steps
    localparam logic [30:0] HALF_PI_Q30 = 31'h6487ED51;
    localparam logic [14:0] QUARTER     = 15'd16384;

    // Series divisors (2n)(2n+1) and their reciprocals, floor(2^shift / d)
    localparam logic [8:0] TERM_DIV [1:SIN_TERMS] = '{
        9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272
    };
    localparam int TERM_SHIFT [1:SIN_TERMS] = '{34, 36, 37, 38, 38, 39, 39, 40};
    localparam logic [31:0] TERM_RECIP [1:SIN_TERMS] = '{
        32'((64'd1 << TERM_SHIFT[1]) / 64'(TERM_DIV[1])),
        32'((64'd1 << TERM_SHIFT[2]) / 64'(TERM_DIV[2])),
        32'((64'd1 << TERM_SHIFT[3]) / 64'(TERM_DIV[3])),
        32'((64'd1 << TERM_SHIFT[4]) / 64'(TERM_DIV[4])),
        32'((64'd1 << TERM_SHIFT[5]) / 64'(TERM_DIV[5])),
        32'((64'd1 << TERM_SHIFT[6]) / 64'(TERM_DIV[6])),
        32'((64'd1 << TERM_SHIFT[7]) / 64'(TERM_DIV[7])),
        32'((64'd1 << TERM_SHIFT[8]) / 64'(TERM_DIV[8]))
    };

    // Register map, indexed by paddr[2]
    localparam logic REG_STEP_U = 1'b0;
    localparam logic REG_STEP_V = 1'b1;
    localparam logic [16:0] CELL_STEP_RESET = 17'h10000;

    // Strip order corner numbering
    localparam logic [1:0] FIRST_CORNER = 2'd0;
    localparam logic [1:0] LAST_CORNER  = 2'd3;

    // Q1.15 sine or cosine, -1.0 to +1.0 inclusive
    typedef logic signed [16:0] trig_t;

    // One sprite request as it travels beside the sine pipeline
    typedef struct packed {
        logic signed [15:0] centre_x;
        logic signed [15:0] centre_y;
        logic [14:0]        half_width;
        logic [14:0]        half_height;
        logic [7:0]         cell_col;
        logic [7:0]         cell_row;
        logic [31:0]        color;
    } sprite_t;

endpackage

>>> design/rotated_sprite_quad_setup_unit.sv
// Rotated sprite quad setup: takes one sprite request (Q12.4 centre, half
// extents, 16-bit binary angle, atlas cell and colour) and returns its four
// corner vertices in triangle strip order, corner 0 to 3, with last_corner
// set on corner 3. A request is taken in any cycle while the pipeline has
// room; the result port gives one vertex per cycle while m_ready is high,
// so the sustained sprite rate is set by that single vertex port. A request
// passes 28 stages of sine and cosine (quarter-wave Taylor series, one term
// per three stages, in two parallel units), then product, rounding and quad
// registers before its first vertex appears. Cell steps sit at byte
// addresses 0 (u) and 4 (v), reset to 1.0 (0x10000), and should only be
// written while no sprite is in flight.
module rotated_sprite_quad_setup_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_centre_x,
    input  logic signed [15:0] s_centre_y,
    input  logic [14:0]        s_half_width,
    input  logic [14:0]        s_half_height,
    input  logic [15:0]        s_angle,
    input  logic [7:0]         s_cell_col,
    input  logic [7:0]         s_cell_row,
    input  logic [31:0]        s_color,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_corner,
    output logic signed [17:0] m_vertex_x,
    output logic signed [17:0] m_vertex_y,
    output logic [24:0]        m_tex_u,
    output logic [24:0]        m_tex_v,
    output logic [31:0]        m_vertex_color,
    output logic               m_last_corner,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rsq_pkg::*;

    logic                   pipe_adv;
    logic                   quad_ready;
    logic [SIN_LATENCY-1:0] pv_reg;
    sprite_t                side_reg [SIN_LATENCY];
    sprite_t                in_sprite;
    logic [15:0]            cos_angle;
    trig_t                  sin_val;
    trig_t                  cos_val;
    logic [16:0]            step_u_reg;
    logic [16:0]            step_v_reg;

    // Pack the request
    assign in_sprite = '{centre_x: s_centre_x, centre_y: s_centre_y,
                         half_width: s_half_width, half_height: s_half_height,
                         cell_col: s_cell_col, cell_row: s_cell_row,
                         color: s_color};

    // Cosine is the sine a quarter turn on
    assign cos_angle = {s_angle[15:14] + 2'd1, s_angle[13:0]};

    // Stall the whole sine pipeline only when its last stage cannot drain
    assign pipe_adv = !pv_reg[SIN_LATENCY-1] || quad_ready;
    assign s_ready  = pipe_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= '0;
        end else if (pipe_adv) begin
            pv_reg <= {pv_reg[SIN_LATENCY-2:0], s_valid};
        end
    end

    // Carry the request beside the sine units
    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            side_reg[0] <= in_sprite;
            for (int i = 1; i < SIN_LATENCY; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    rsq_sine_pipe u_sine (
        .aclk    (aclk),
        .advance (pipe_adv),
        .angle   (s_angle),
        .sine    (sin_val)
    );

    rsq_sine_pipe u_cosine (
        .aclk    (aclk),
        .advance (pipe_adv),
        .angle   (cos_angle),
        .sine    (cos_val)
    );

    rsq_corner_gen u_corner (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (pv_reg[SIN_LATENCY-1]),
        .in_ready       (quad_ready),
        .sin_val        (sin_val),
        .cos_val        (cos_val),
        .sprite         (side_reg[SIN_LATENCY-1]),
        .step_u         (step_u_reg),
        .step_v         (step_v_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_corner       (m_corner),
        .m_vertex_x     (m_vertex_x),
        .m_vertex_y     (m_vertex_y),
        .m_tex_u        (m_tex_u),
        .m_tex_v        (m_tex_v),
        .m_vertex_color (m_vertex_color),
        .m_last_corner  (m_last_corner)
    );

    // Register writes in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_u_reg <= CELL_STEP_RESET;
            step_v_reg <= CELL_STEP_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_STEP_U: step_u_reg <= pwdata[16:0];
                REG_STEP_V: step_v_reg <= pwdata[16:0];
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[2])
            REG_STEP_U: prdata = 32'(step_u_reg);
            REG_STEP_V: prdata = 32'(step_v_reg);
        endcase
    end

    assign pready = 1'b1;

endmodule

>>> design/rsq_sine_pipe.sv
module rsq_sine_pipe (
    input  logic           aclk,
    input  logic           advance,
    input  logic [15:0]    angle,
    output rsq_pkg::trig_t sine
);
    import rsq_pkg::*;

    typedef struct packed {
        logic [31:0]        x2;
        logic signed [32:0] sum;
        logic               neg;
    } carry_t;

    logic [14:0]        k_idx;
    logic [45:0]        x_prod;
    logic [61:0]        xx_prod;
    logic [30:0]        x_reg;
    logic               neg0_reg;

    carry_t             car_reg  [0:SIN_TERMS];
    logic [30:0]        pend_reg [0:SIN_TERMS];
    carry_t             cara_reg [1:SIN_TERMS];
    logic [31:0]        ta_reg   [1:SIN_TERMS];
    carry_t             carb_reg [1:SIN_TERMS];
    logic [31:0]        tb_reg   [1:SIN_TERMS];
    logic [30:0]        q0_reg   [1:SIN_TERMS];

    logic [31:0]        ta_next   [1:SIN_TERMS];
    logic signed [32:0] suma_next [1:SIN_TERMS];
    logic [30:0]        q0_next   [1:SIN_TERMS];
    logic [32:0]        rem_next  [1:SIN_TERMS];
    logic [30:0]        q_next    [1:SIN_TERMS];

    logic signed [32:0] sumf_next;
    logic signed [32:0] sumf_reg;
    logic               negf_reg;
    logic [32:0]        pos_sum;
    logic [33:0]        rnd_sum;
    logic [15:0]        mag;
    trig_t              sine_next;
    trig_t              sine_reg;

    // Fold the angle into the first quadrant and scale to radians in Q30
    always_comb begin
        k_idx  = angle[14] ? (QUARTER - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
        x_prod = 46'(HALF_PI_Q30) * 46'(k_idx) + 46'd8192;
    end

    // Square of x, rounded to Q30
    assign xx_prod = 62'(x_reg) * 62'(x_reg) + 62'(64'd1 << 29);

    // Series terms: multiply by x^2, multiply by the divisor's reciprocal, correct by one
    always_comb begin
        for (int n = 1; n <= SIN_TERMS; n++) begin
            ta_next[n] = 32'((64'(pend_reg[n-1]) * 64'(car_reg[n-1].x2)) >> 30);
            if (((n - 1) & 1) != 0) begin
                suma_next[n] = car_reg[n-1].sum - $signed({2'b00, pend_reg[n-1]});
            end else begin
                suma_next[n] = car_reg[n-1].sum + $signed({2'b00, pend_reg[n-1]});
            end
            q0_next[n]  = 31'((64'(ta_reg[n]) * 64'(TERM_RECIP[n])) >> TERM_SHIFT[n]);
            rem_next[n] = 33'(tb_reg[n]) - 33'(41'(q0_reg[n]) * 41'(TERM_DIV[n]));
            q_next[n]   = (rem_next[n] >= 33'(TERM_DIV[n])) ? q0_reg[n] + 31'd1
                                                             : q0_reg[n];
        end
    end

    // Add the last term
    always_comb begin
        if ((SIN_TERMS & 1) != 0) begin
            sumf_next = car_reg[SIN_TERMS].sum - $signed({2'b00, pend_reg[SIN_TERMS]});
        end else begin
            sumf_next = car_reg[SIN_TERMS].sum + $signed({2'b00, pend_reg[SIN_TERMS]});
        end
    end

    // Clamp, round Q30 to Q15, clamp to one, restore the sign
    always_comb begin
        pos_sum = sumf_reg[32] ? '0 : sumf_reg;
        rnd_sum = {1'b0, pos_sum} + 34'd16384;
        mag     = (rnd_sum[33:15] > 19'd32768) ? 16'h8000 : rnd_sum[30:15];
        sine_next = negf_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // Advance every stage together
    always_ff @(posedge aclk) begin
        if (advance) begin
            x_reg       <= x_prod[44:14];
            neg0_reg    <= angle[15];
            car_reg[0]  <= '{x2: xx_prod[61:30], sum: '0, neg: neg0_reg};
            pend_reg[0] <= x_reg;
            for (int n = 1; n <= SIN_TERMS; n++) begin
                cara_reg[n] <= '{x2: car_reg[n-1].x2, sum: suma_next[n],
                                 neg: car_reg[n-1].neg};
                ta_reg[n]   <= ta_next[n];
                carb_reg[n] <= cara_reg[n];
                tb_reg[n]   <= ta_reg[n];
                q0_reg[n]   <= q0_next[n];
                car_reg[n]  <= carb_reg[n];
                pend_reg[n] <= q_next[n];
            end
            sumf_reg <= sumf_next;
            negf_reg <= car_reg[SIN_TERMS].neg;
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

>>> design/rsq_corner_gen.sv
module rsq_corner_gen (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rsq_pkg::trig_t     sin_val,
    input  rsq_pkg::trig_t     cos_val,
    input  rsq_pkg::sprite_t   sprite,
    input  logic [16:0]        step_u,
    input  logic [16:0]        step_v,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_corner,
    output logic signed [17:0] m_vertex_x,
    output logic signed [17:0] m_vertex_y,
    output logic [24:0]        m_tex_u,
    output logic [24:0]        m_tex_v,
    output logic [31:0]        m_vertex_color,
    output logic               m_last_corner
);
    import rsq_pkg::*;

    // Round a Q12.4 x Q1.15 product to Q12.4, ties up
    function automatic logic signed [16:0] round_q15(input logic signed [32:0] p);
        logic signed [33:0] b;
        b = $signed({p[32], p}) + 34'sd16384;
        return b[31:15];
    endfunction

    logic               adv1;
    logic               adv2;
    logic               quad_free;
    logic               out_take;

    // Stage 1: products
    logic               v1_reg;
    logic signed [32:0] hw_c_reg, hw_s_reg, hh_c_reg, hh_s_reg;
    logic [24:0]        tu0_1_reg, tu1_1_reg, tv0_1_reg, tv1_1_reg;
    logic signed [15:0] cx1_reg, cy1_reg;
    logic [31:0]        color1_reg;
    logic [25:0]        tu1_prod, tv1_prod;

    // Stage 2: rounded terms for both signs
    logic               v2_reg;
    logic signed [16:0] hw_c_p_reg, hw_c_n_reg, hw_s_p_reg, hw_s_n_reg;
    logic signed [16:0] hh_c_p_reg, hh_c_n_reg, hh_s_p_reg, hh_s_n_reg;
    logic [24:0]        tu0_2_reg, tu1_2_reg, tv0_2_reg, tv1_2_reg;
    logic signed [15:0] cx2_reg, cy2_reg;
    logic [31:0]        color2_reg;

    // Stage 3: one quad, read out a corner at a time
    logic               quad_valid_reg;
    logic [1:0]         corner_reg;
    logic signed [17:0] vx_next [4];
    logic signed [17:0] vy_next [4];
    logic signed [17:0] vx_reg  [4];
    logic signed [17:0] vy_reg  [4];
    logic [24:0]        tu0_reg, tu1_reg, tv0_reg, tv1_reg;
    logic [31:0]        color_reg;

    // Handshake chain from the result port back to the input
    assign out_take  = quad_valid_reg && m_ready;
    assign quad_free = !quad_valid_reg || (m_ready && (corner_reg == LAST_CORNER));
    assign adv2      = !v2_reg || quad_free;
    assign adv1      = !v1_reg || adv2;
    assign in_ready  = adv1;

    assign tu1_prod = 26'(step_u) * (26'(sprite.cell_col) + 26'd1);
    assign tv1_prod = 26'(step_v) * (26'(sprite.cell_row) + 26'd1);

    // Stage 1: offset and texture products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            hw_c_reg   <= $signed({1'b0, sprite.half_width}) * cos_val;
            hw_s_reg   <= $signed({1'b0, sprite.half_width}) * sin_val;
            hh_c_reg   <= $signed({1'b0, sprite.half_height}) * cos_val;
            hh_s_reg   <= $signed({1'b0, sprite.half_height}) * sin_val;
            tu0_1_reg  <= 25'(step_u) * 25'(sprite.cell_col);
            tv0_1_reg  <= 25'(step_v) * 25'(sprite.cell_row);
            tu1_1_reg  <= tu1_prod[24:0];
            tv1_1_reg  <= tv1_prod[24:0];
            cx1_reg    <= sprite.centre_x;
            cy1_reg    <= sprite.centre_y;
            color1_reg <= sprite.color;
        end
    end

    // Stage 2: round each product for a positive and a negative offset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            hw_c_p_reg <= round_q15(hw_c_reg);
            hw_c_n_reg <= round_q15(-hw_c_reg);
            hw_s_p_reg <= round_q15(hw_s_reg);
            hw_s_n_reg <= round_q15(-hw_s_reg);
            hh_c_p_reg <= round_q15(hh_c_reg);
            hh_c_n_reg <= round_q15(-hh_c_reg);
            hh_s_p_reg <= round_q15(hh_s_reg);
            hh_s_n_reg <= round_q15(-hh_s_reg);
            tu0_2_reg  <= tu0_1_reg;
            tu1_2_reg  <= tu1_1_reg;
            tv0_2_reg  <= tv0_1_reg;
            tv1_2_reg  <= tv1_1_reg;
            cx2_reg    <= cx1_reg;
            cy2_reg    <= cy1_reg;
            color2_reg <= color1_reg;
        end
    end

    // Corner positions: bit 0 picks the x offset sign, bit 1 the y sign
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            vx_next[k] = 18'(cx2_reg)
                       + 18'(((k & 1) != 0) ? hw_c_p_reg : hw_c_n_reg)
                       + 18'(((k & 2) != 0) ? hh_s_p_reg : hh_s_n_reg);
            vy_next[k] = 18'(cy2_reg)
                       + 18'(((k & 2) != 0) ? hh_c_p_reg : hh_c_n_reg)
                       - 18'(((k & 1) != 0) ? hw_s_p_reg : hw_s_n_reg);
        end
    end

    // Stage 3: load a quad when the stage is empty or the last corner leaves, step the corner
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad_valid_reg <= 1'b0;
            corner_reg     <= FIRST_CORNER;
        end else if (quad_free) begin
            quad_valid_reg <= v2_reg;
            corner_reg     <= FIRST_CORNER;
        end else if (out_take) begin
            corner_reg     <= corner_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (quad_free && v2_reg) begin
            for (int k = 0; k < 4; k++) begin
                vx_reg[k] <= vx_next[k];
                vy_reg[k] <= vy_next[k];
            end
            tu0_reg   <= tu0_2_reg;
            tu1_reg   <= tu1_2_reg;
            tv0_reg   <= tv0_2_reg;
            tv1_reg   <= tv1_2_reg;
            color_reg <= color2_reg;
        end
    end

    // Present the current corner
    assign m_valid        = quad_valid_reg;
    assign m_corner       = corner_reg;
    assign m_vertex_x     = vx_reg[corner_reg];
    assign m_vertex_y     = vy_reg[corner_reg];
    assign m_tex_u        = corner_reg[0] ? tu1_reg : tu0_reg;
    assign m_tex_v        = corner_reg[1] ? tv1_reg : tv0_reg;
    assign m_vertex_color = color_reg;
    assign m_last_corner  = (corner_reg == LAST_CORNER);

`ifndef SYNTHESIS
    // A taken corner that is not the last is followed by the next corner
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_corner) |=>
        (m_valid && (m_corner == $past(m_corner) + 2'd1)))
        else $error("corner did not advance within a quad");

    // After the last corner a new quad starts at the first corner
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_corner) |=>
        (!m_valid || (m_corner == FIRST_CORNER)))
        else $error("new quad did not start at the first corner");

    // Color holds across the corners of one quad
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_corner) |=>
        (m_vertex_color == $past(m_vertex_color)))
        else $error("color changed inside a quad");

    // The first two corners share the top texture row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && (m_corner == FIRST_CORNER)) |=>
        (m_tex_v == $past(m_tex_v)))
        else $error("tex_v differs between the first two corners");
`endif

endmodule
